[rtl/core/rstk_pkg.sv]
// Shared types, constants and defaults for the resizing stack.
package rstk_pkg;

    // Default sizing of the stack memory
    localparam int DEPTH_DEF  = 1024;
    localparam int DATA_W_DEF = 32;

    // Field widths fixed by the interface
    localparam int CFG_W = 11;
    localparam int VAL_W = 32;
    localparam int CNT_OUT_W = 11;

    // Reset value of the capacity floor, the capacity and the peak
    localparam logic [CFG_W-1:0] MIN_CAP_RST = 11'd10;

    // Value returned by a pop of an empty stack
    localparam logic signed [VAL_W-1:0] EMPTY_CODE = -32'sd99;

    // Request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // One request item
    typedef struct packed {
        logic                    req_type;
        logic signed [VAL_W-1:0] push_value;
    } t_req;

    // One result item
    typedef struct packed {
        logic signed [VAL_W-1:0] pop_value;
        logic                    empty_flag;
        logic                    overflow_flag;
        logic [CNT_OUT_W-1:0]    item_count;
        logic [CNT_OUT_W-1:0]    cur_capacity;
        logic [VAL_W-1:0]        resize_total;
        logic [CNT_OUT_W-1:0]    peak_capacity;
    } t_rsp;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;
        logic resp;
    } t_cmd;

endpackage

[rtl/core/resizing_stack_with_capacity_tracking.sv]
// Top level of the resizing stack with logical capacity tracking.
//
//   channel   | ports                   | handshake
//   ----------+-------------------------+-------------------------------------
//   request   | start, busy, i_req      | taken on an edge with start & !busy
//   result    | o_done, o_rsp           | valid for one cycle, always taken
//   config    | i_cfg_we, i_cfg_wdata   | min_capacity written when i_cfg_we
//
// For each item the accept cycle updates the stack and issues the memory read,
// and the next cycle shows the result while busy is high. The result comes
// from the registered read port of the stack memory. Synchronous active-low
// reset clears count and resize total, sets capacity and peak to MIN_CAP_RST;
// the memory is not cleared. The receiver cannot stall, so o_done is one cycle.
module resizing_stack_with_capacity_tracking #(
    parameter int DEPTH      = rstk_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rstk_pkg::DATA_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rstk_pkg::t_req              i_req,
    output logic                        o_done,
    output rstk_pkg::t_rsp              o_rsp,
    input  logic                        i_cfg_we,
    input  logic [rstk_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import rstk_pkg::*;

    t_cmd w_cmd;

    // Sequence each request
    rstk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // Stack storage and capacity bookkeeping
    rstk_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_rsp)
    );

    // Mark the result cycle
    assign o_done = w_cmd.resp;

endmodule

[rtl/core/rstk_ctrl.sv]
// Controller: accepts a request, then presents its result for one cycle.
module rstk_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output rstk_pkg::t_cmd  o_cmd
);
    import rstk_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // Advance between waiting for a request and answering it
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive handshake and datapath commands
    assign busy       = (r_state != S_IDLE);
    assign o_cmd.exec = (r_state == S_IDLE) && start;
    assign o_cmd.resp = (r_state == S_RESP);

endmodule

[rtl/core/rstk_dp.sv]
// Datapath: stack memory, item count, logical capacity and statistics.
module rstk_dp #(
    parameter int DEPTH      = rstk_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rstk_pkg::DATA_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rstk_pkg::t_cmd              i_cmd,
    input  rstk_pkg::t_req              i_req,
    input  logic                        i_cfg_we,
    input  logic [rstk_pkg::CFG_W-1:0]  i_cfg_wdata,
    output rstk_pkg::t_rsp              o_rsp
);
    import rstk_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(DEPTH);
    localparam logic [LW-1:0]    DEPTH_L = LW'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cap,   n_cap;
    logic [CNT_W-1:0] r_peak,  n_peak;
    logic [VAL_W-1:0] r_resizes, n_resizes;
    logic [CFG_W-1:0] r_min_cap;

    logic r_is_pop;
    logic r_empty;
    logic r_ovf;

    logic             is_pop;
    logic             is_full;
    logic             is_empty;
    logic             do_push;
    logic             do_pop;
    logic [CNT_W-1:0] chk;
    logic [CNT_W:0]   cap2;
    logic [CNT_W-1:0] grow_cap;
    logic [CNT_W-1:0] half_cap;
    logic [CNT_W-1:0] shrink_cap;
    logic [LW-1:0]    min_ext;
    logic [CNT_W-1:0] floor_cap;
    logic             grow;
    logic             grow_chg;
    logic             shrink;
    logic             bump;

    // Decode the request against the current fill
    assign is_pop   = (i_req.req_type == REQ_POP);
    assign is_full  = (r_count == DEPTH_C);
    assign is_empty = (r_count == '0);
    assign do_push  = i_cmd.exec && !is_pop && !is_full;
    assign do_pop   = i_cmd.exec && is_pop && !is_empty;

    // Clamp the floor into one to DEPTH
    assign min_ext = LW'(r_min_cap);
    always_comb begin
        if (min_ext == '0) begin
            floor_cap = CNT_W'(1);
        end else if (min_ext > DEPTH_L) begin
            floor_cap = DEPTH_C;
        end else begin
            floor_cap = CNT_W'(min_ext);
        end
    end

    // Resize check: count after a push, or before a pop
    assign chk        = is_pop ? r_count : r_count + CNT_W'(1);
    assign cap2       = {r_cap, 1'b0};
    assign grow_cap   = (cap2 > DEPTH_X) ? DEPTH_C : cap2[CNT_W-1:0];
    assign half_cap   = r_cap >> 1;
    assign shrink_cap = (half_cap < floor_cap) ? floor_cap : half_cap;
    assign grow       = (chk >= r_cap);
    assign grow_chg   = grow && (grow_cap != r_cap);
    assign shrink     = !grow && (chk != '0) && ((chk - CNT_W'(1)) < half_cap)
                        && (r_cap > floor_cap);
    assign bump       = (do_push || do_pop) && (grow_chg || shrink);

    // Next capacity, peak, count and resize total
    always_comb begin
        n_count   = r_count;
        n_cap     = r_cap;
        n_peak    = r_peak;
        n_resizes = r_resizes;
        if (do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
        if ((do_push || do_pop) && grow_chg) begin
            n_cap = grow_cap;
            if (r_peak < grow_cap) begin
                n_peak = grow_cap;
            end
        end else if ((do_push || do_pop) && shrink) begin
            n_cap = shrink_cap;
        end
        if (bump && (r_resizes != '1)) begin
            n_resizes = r_resizes + VAL_W'(1);
        end
    end

    // Hold stack state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cap     <= CNT_W'(MIN_CAP_RST);
            r_peak    <= CNT_W'(MIN_CAP_RST);
            r_resizes <= '0;
            r_min_cap <= MIN_CAP_RST;
        end else begin
            r_count   <= n_count;
            r_cap     <= n_cap;
            r_peak    <= n_peak;
            r_resizes <= n_resizes;
            if (i_cfg_we) begin
                r_min_cap <= i_cfg_wdata;
            end
        end
    end

    // Capture result flags of the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_is_pop <= is_pop;
            r_empty  <= is_pop && is_empty;
            r_ovf    <= !is_pop && is_full;
        end
    end

    // Write on push, registered read of the top entry on pop
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_count[AW-1:0]] <= DATA_WIDTH'(i_req.push_value);
        end
        if (do_pop) begin
            r_rd_data <= mem[AW'(r_count - CNT_W'(1))];
        end
    end

    // Build the result item
    always_comb begin
        if (r_empty) begin
            o_rsp.pop_value = EMPTY_CODE;
        end else if (r_is_pop) begin
            o_rsp.pop_value = VAL_W'(r_rd_data);
        end else begin
            o_rsp.pop_value = '0;
        end
        o_rsp.empty_flag    = r_empty;
        o_rsp.overflow_flag = r_ovf;
        o_rsp.item_count    = CNT_OUT_W'(r_count);
        o_rsp.cur_capacity  = CNT_OUT_W'(r_cap);
        o_rsp.resize_total  = r_resizes;
        o_rsp.peak_capacity = CNT_OUT_W'(r_peak);
    end

endmodule
